// File: src/rmm_pkg.sv
// rmm_pkg: shared types and codes for the running median multiset block
// word layouts, command and status codes, controller to datapath bundles
// no dependencies
`timescale 1ns / 1ps

package rmm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] median;
        logic [COUNT_W-1:0]        count;
    } res_word_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_TOP,
        IDX_MID,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        WA_IDX,
        WA_INC,
        WA_DEC
    } wr_addr_sel_t;

    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } wr_data_sel_t;

    typedef enum logic [1:0] {
        MED_ZERO,
        MED_RDATA,
        MED_HALF
    } med_sel_t;

    typedef struct packed {
        logic         load;
        idx_op_t      idx_op;
        logic         wr_en;
        wr_addr_sel_t wa_sel;
        wr_data_sel_t wd_sel;
        logic         cnt_inc;
        logic         cnt_dec;
        logic         found_clr;
        logic         found_set;
        logic         lo_load;
        logic         res_load;
        logic [1:0]   res_status;
        med_sel_t     med_sel;
        logic         out_load;
    } rmm_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic odd;
        logic idx_zero;
        logic idx_last;
        logic gt;
        logic match;
        logic found;
    } rmm_flags_t;

endpackage

// File: src/running_median_multiset.sv
// running_median_multiset: top level, running median over a bounded multiset
// instantiates rmm_ctrl and rmm_datapath
// depends on rmm_pkg
//
// command channel: cmd_valid / cmd_stall carry a cmd_word (command, value).
//   insert adds value, remove takes out one instance of value, query asks
//   for the median. a word is taken when cmd_valid is high and cmd_stall low.
// result channel: res_valid / res_stall carry one res_word (status, median,
//   count) per command word, in command order.
// one command at a time; cmd_stall is high from the cycle after a word is
//   taken until its result is loaded, so no word is taken while one is in flight.
// steps per command, with n values held:
//   insert: scan down from the top, moving each held value greater than the
//   new one up one slot; remove: scan all n values; query: read the middle
//   value (odd n) or the two middle values (even n); rejected inserts, removes
//   and queries on an empty set skip the scan. the sorted entry memory does one
//   read and one write per cycle while entries are searched and shifted.
// a result word waits in the output register while res_stall is high, and a
//   finished result waits behind it; no new command is taken until it moves in.
// reset clears the count to zero; entry memory is not cleared.
`timescale 1ns / 1ps

module running_median_multiset #(
    parameter int CAPACITY = rmm_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  rmm_pkg::cmd_word_t cmd_word,
    output logic               res_valid,
    input  logic               res_stall,
    output rmm_pkg::res_word_t res_word
);

    rmm_pkg::rmm_ctrl_t  ctrl;
    rmm_pkg::rmm_flags_t flags;

    rmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (cmd_word.command),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    rmm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .value    (cmd_word.value),
        .flags    (flags),
        .res_word (res_word)
    );

endmodule

// File: src/rmm_datapath.sv
// rmm_datapath: sorted entry memory, scan index, count and result registers
// executes the commands issued by rmm_ctrl and reports compare flags
// depends on rmm_pkg
`timescale 1ns / 1ps

module rmm_datapath #(
    parameter int CAPACITY = rmm_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmm_pkg::rmm_ctrl_t                ctrl,
    input  logic signed [rmm_pkg::VALUE_W-1:0] value,
    output rmm_pkg::rmm_flags_t               flags,
    output rmm_pkg::res_word_t                res_word
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = rmm_pkg::VALUE_W;

    logic [VW-1:0] sorted_mem [CAPACITY];

    logic signed [VW-1:0] value_reg;
    logic signed [VW-1:0] rdata_reg;
    logic signed [VW-1:0] lo_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        idx_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 found_reg;
    logic [AW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;
    logic [VW:0]          sum;
    logic [VW:0]          sum_adj;
    logic [VW-1:0]        med_sel_val;
    logic [1:0]           res_status_reg;
    logic [VW-1:0]        res_median_reg;
    logic [rmm_pkg::COUNT_W-1:0] res_count_reg;
    rmm_pkg::res_word_t   out_word_reg;

    always_comb
    begin
        case (ctrl.idx_op)
            rmm_pkg::IDX_ZERO: idx_next = '0;
            rmm_pkg::IDX_TOP:  idx_next = count_reg - CW'(1);
            rmm_pkg::IDX_MID:  idx_next = (count_reg >> 1) - CW'(!count_reg[0]);
            rmm_pkg::IDX_INC:  idx_next = idx_reg + CW'(1);
            rmm_pkg::IDX_DEC:  idx_next = idx_reg - CW'(1);
            default:           idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.wa_sel)
            rmm_pkg::WA_INC: wr_addr = AW'(idx_reg + CW'(1));
            rmm_pkg::WA_DEC: wr_addr = AW'(idx_reg - CW'(1));
            default:         wr_addr = AW'(idx_reg);
        endcase
        wr_data = (ctrl.wd_sel == rmm_pkg::WD_RDATA) ? rdata_reg : value_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // even-count median: 33-bit sum halved toward zero
    assign sum     = {lo_reg[VW-1], lo_reg} + {rdata_reg[VW-1], rdata_reg};
    assign sum_adj = sum + {{VW{1'b0}}, sum[VW]};

    always_comb
    begin
        case (ctrl.med_sel)
            rmm_pkg::MED_RDATA: med_sel_val = rdata_reg;
            rmm_pkg::MED_HALF:  med_sel_val = sum_adj[VW:1];
            default:            med_sel_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            sorted_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= sorted_mem[idx_next[AW-1:0]];
        if (ctrl.load)
        begin
            value_reg <= value;
        end
        if (ctrl.lo_load)
        begin
            lo_reg <= rdata_reg;
        end
        if (ctrl.res_load)
        begin
            res_status_reg <= ctrl.res_status;
            res_median_reg <= med_sel_val;
            res_count_reg  <= rmm_pkg::COUNT_W'(count_next);
        end
        if (ctrl.out_load)
        begin
            out_word_reg.status <= res_status_reg;
            out_word_reg.median <= res_median_reg;
            out_word_reg.count  <= res_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (ctrl.found_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (ctrl.found_set)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign flags.empty    = (count_reg == '0);
    assign flags.full     = (count_reg == CW'(CAPACITY));
    assign flags.odd      = count_reg[0];
    assign flags.idx_zero = (idx_reg == '0);
    assign flags.idx_last = (idx_reg == count_reg - CW'(1));
    assign flags.gt       = (rdata_reg > value_reg);
    assign flags.match    = (rdata_reg == value_reg);
    assign flags.found    = found_reg;

    assign res_word = out_word_reg;

endmodule

// File: src/rmm_ctrl.sv
// rmm_ctrl: sequencer for insert, remove and query commands
// drives datapath commands and both channel handshakes
// depends on rmm_pkg
`timescale 1ns / 1ps

module rmm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          command,
    output logic                res_valid,
    input  logic                res_stall,
    input  rmm_pkg::rmm_flags_t flags,
    output rmm_pkg::rmm_ctrl_t  ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PUT,
        S_INS_SCAN,
        S_REM_SCAN,
        S_Q_LO,
        S_Q_HI,
        S_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] op_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       slot_free;

    assign slot_free = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        ctrl            = '0;
        ctrl.idx_op     = rmm_pkg::IDX_HOLD;
        ctrl.wa_sel     = rmm_pkg::WA_IDX;
        ctrl.wd_sel     = rmm_pkg::WD_VALUE;
        ctrl.med_sel    = rmm_pkg::MED_ZERO;
        ctrl.res_status = rmm_pkg::ST_OK;
        state_next      = state_reg;
        res_valid_next  = res_valid_reg && res_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (op_reg)
                    rmm_pkg::CMD_INSERT:
                    begin
                        if (flags.full)
                        begin
                            ctrl.res_load   = 1'b1;
                            ctrl.res_status = rmm_pkg::ST_FULL;
                            state_next      = S_OUT;
                        end
                        else if (flags.empty)
                        begin
                            ctrl.idx_op = rmm_pkg::IDX_ZERO;
                            state_next  = S_PUT;
                        end
                        else
                        begin
                            ctrl.idx_op = rmm_pkg::IDX_TOP;
                            state_next  = S_INS_SCAN;
                        end
                    end
                    rmm_pkg::CMD_REMOVE:
                    begin
                        if (flags.empty)
                        begin
                            ctrl.res_load   = 1'b1;
                            ctrl.res_status = rmm_pkg::ST_NOT_FOUND;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            ctrl.idx_op    = rmm_pkg::IDX_ZERO;
                            ctrl.found_clr = 1'b1;
                            state_next     = S_REM_SCAN;
                        end
                    end
                    rmm_pkg::CMD_QUERY:
                    begin
                        if (flags.empty)
                        begin
                            ctrl.res_load   = 1'b1;
                            ctrl.res_status = rmm_pkg::ST_EMPTY;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            ctrl.idx_op = rmm_pkg::IDX_MID;
                            state_next  = S_Q_LO;
                        end
                    end
                    default:
                    begin
                        ctrl.res_load = 1'b1;
                        state_next    = S_OUT;
                    end
                endcase
            end
            S_PUT:
            begin
                ctrl.wr_en    = 1'b1;
                ctrl.cnt_inc  = 1'b1;
                ctrl.res_load = 1'b1;
                state_next    = S_OUT;
            end
            S_INS_SCAN:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wa_sel = rmm_pkg::WA_INC;
                if (flags.gt)
                begin
                    ctrl.wd_sel = rmm_pkg::WD_RDATA;
                    if (flags.idx_zero)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ctrl.idx_op = rmm_pkg::IDX_DEC;
                    end
                end
                else
                begin
                    ctrl.cnt_inc  = 1'b1;
                    ctrl.res_load = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_REM_SCAN:
            begin
                // entries after the match slide down by one
                if (flags.found)
                begin
                    ctrl.wr_en  = 1'b1;
                    ctrl.wa_sel = rmm_pkg::WA_DEC;
                    ctrl.wd_sel = rmm_pkg::WD_RDATA;
                end
                else if (flags.match)
                begin
                    ctrl.found_set = 1'b1;
                end
                if (flags.idx_last)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = S_OUT;
                    if (flags.found || flags.match)
                    begin
                        ctrl.cnt_dec = 1'b1;
                    end
                    else
                    begin
                        ctrl.res_status = rmm_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    ctrl.idx_op = rmm_pkg::IDX_INC;
                end
            end
            S_Q_LO:
            begin
                if (flags.odd)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.med_sel  = rmm_pkg::MED_RDATA;
                    state_next    = S_OUT;
                end
                else
                begin
                    ctrl.lo_load = 1'b1;
                    ctrl.idx_op  = rmm_pkg::IDX_INC;
                    state_next   = S_Q_HI;
                end
            end
            S_Q_HI:
            begin
                ctrl.res_load = 1'b1;
                ctrl.med_sel  = rmm_pkg::MED_HALF;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    ctrl.out_load  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= rmm_pkg::CMD_INSERT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == S_IDLE && cmd_valid)
            begin
                op_reg <= command;
            end
        end
    end

endmodule

// File: tb/sv/tb_running_median_multiset.sv
// tb_running_median_multiset: self-checking bench for the running median multiset block
// drives insert, remove, query and unused command words and checks each result word
// depends on rmm_pkg and running_median_multiset
`timescale 1ns / 1ps

module tb_running_median_multiset;

    localparam int STORE_DEPTH  = rmm_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS = 600;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic signed [rmm_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [rmm_pkg::VALUE_W-1:0] VAL_MIN = 32'sh80000000;

    typedef enum int {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN
    } phase_t;

    class median_tracker;
        logic signed [rmm_pkg::VALUE_W-1:0] held_values[$];
        rmm_pkg::res_word_t pending_results[$];
        int mismatches;
        int results_seen;
        int words_noted;
        int medians_ok;
        int empty_queries;
        int dropped_inserts;
        int missed_removes;
        int peak_count;

        function new();
            mismatches      = 0;
            results_seen    = 0;
            words_noted     = 0;
            medians_ok      = 0;
            empty_queries   = 0;
            dropped_inserts = 0;
            missed_removes  = 0;
            peak_count      = 0;
        endfunction

        function int held_count();
            return held_values.size();
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function logic signed [rmm_pkg::VALUE_W-1:0] any_held();
            return held_values[$urandom_range(0, held_values.size() - 1)];
        endfunction

        function void note_command(rmm_pkg::cmd_word_t w);
            rmm_pkg::res_word_t want;
            int pos;
            int n;
            logic signed [rmm_pkg::VALUE_W:0] pair_sum;
            want = '0;
            n = held_values.size();
            case (w.command)
                rmm_pkg::CMD_INSERT:
                begin
                    if (n >= STORE_DEPTH)
                    begin
                        want.status = rmm_pkg::ST_FULL;
                        dropped_inserts++;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < n && held_values[pos] <= w.value)
                            pos++;
                        held_values.insert(pos, w.value);
                    end
                end
                rmm_pkg::CMD_REMOVE:
                begin
                    pos = 0;
                    while (pos < n && held_values[pos] != w.value)
                        pos++;
                    if (pos >= n)
                    begin
                        want.status = rmm_pkg::ST_NOT_FOUND;
                        missed_removes++;
                    end
                    else
                        held_values.delete(pos);
                end
                rmm_pkg::CMD_QUERY:
                begin
                    if (n == 0)
                    begin
                        want.status = rmm_pkg::ST_EMPTY;
                        empty_queries++;
                    end
                    else
                    begin
                        medians_ok++;
                        if (n % 2 == 1)
                            want.median = held_values[n / 2];
                        else
                        begin
                            // 33-bit sum, signed divide truncates toward zero
                            pair_sum = held_values[n / 2 - 1] + held_values[n / 2];
                            pair_sum = pair_sum / 2;
                            want.median = pair_sum[rmm_pkg::VALUE_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            want.count = rmm_pkg::COUNT_W'(held_values.size());
            if (held_values.size() > peak_count)
                peak_count = held_values.size();
            words_noted++;
            pending_results = {pending_results, want};
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(rmm_pkg::res_word_t got);
            rmm_pkg::res_word_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result word with no command outstanding (status %0d count %0d)",
                                 got.status, got.count));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("word %0d status %0d, expected %0d",
                                 results_seen, got.status, want.status));
            if (got.median !== want.median)
                report($sformatf("word %0d median %0d, expected %0d",
                                 results_seen, got.median, want.median));
            if (got.count !== want.count)
                report($sformatf("word %0d count %0d, expected %0d",
                                 results_seen, got.count, want.count));
            results_seen++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    rmm_pkg::cmd_word_t cmd_word = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    rmm_pkg::res_word_t res_word;

    median_tracker sb = new();

    int burst_left = 0;
    int words_sent = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    running_median_multiset #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern, a random mode chosen anew whenever stall_left runs out
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= (stall_phase % 5 < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_word);
    end

    function automatic logic signed [rmm_pkg::VALUE_W-1:0] any_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
            4:
            begin
                case ($urandom_range(0, 5))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return VAL_MAX - 1;
                    3: return VAL_MIN + 1;
                    4: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input logic [1:0] op,
                         input logic signed [rmm_pkg::VALUE_W-1:0] val);
        rmm_pkg::cmd_word_t w;
        int gap;
        w.command = op;
        w.value   = val;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(w);
        if (op != CMD_NOP)
            words_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        phase_t kind;
        int phase_no;
        int extra;
        int target;
        int pick;
        int guard;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty set, extremes, overflow-free averaging, duplicates
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(rmm_pkg::CMD_REMOVE, 32'sd5);
        issue(CMD_NOP, '1);
        issue(rmm_pkg::CMD_INSERT, VAL_MAX);
        issue(rmm_pkg::CMD_QUERY, '1);
        issue(rmm_pkg::CMD_INSERT, VAL_MAX);
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(rmm_pkg::CMD_REMOVE, VAL_MAX);
        issue(rmm_pkg::CMD_INSERT, VAL_MIN);
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(rmm_pkg::CMD_REMOVE, VAL_MAX);
        issue(rmm_pkg::CMD_INSERT, VAL_MIN);
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(rmm_pkg::CMD_REMOVE, VAL_MIN);
        issue(rmm_pkg::CMD_REMOVE, VAL_MIN);
        issue(rmm_pkg::CMD_INSERT, -32'sd3);
        issue(rmm_pkg::CMD_INSERT, -32'sd4);
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(rmm_pkg::CMD_REMOVE, 32'sd7);
        issue(rmm_pkg::CMD_INSERT, '0);
        issue(rmm_pkg::CMD_INSERT, -32'sd3);
        issue(rmm_pkg::CMD_REMOVE, -32'sd3);
        issue(rmm_pkg::CMD_QUERY, '0);
        issue(CMD_NOP, '0);

        // random: fill to capacity, drain, and mixed traffic
        target = words_sent + RANDOM_WORDS;
        phase_no = 0;
        while (words_sent < target)
        begin
            if (phase_no == 0)
                kind = PH_FILL;
            else if (phase_no == 1)
                kind = PH_DRAIN;
            else
                kind = phase_t'($urandom_range(0, 2));
            case (kind)
                PH_FILL:
                begin
                    extra = $urandom_range(1, 5);
                    while (extra > 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            issue(rmm_pkg::CMD_QUERY, $urandom);
                        else
                        begin
                            if (sb.held_count() >= STORE_DEPTH)
                                extra--;
                            issue(rmm_pkg::CMD_INSERT, any_value());
                        end
                    end
                end
                PH_DRAIN:
                begin
                    while (sb.held_count() > 0)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 2)
                            issue(rmm_pkg::CMD_QUERY, $urandom);
                        else if (pick == 2)
                            issue(rmm_pkg::CMD_REMOVE, any_value());
                        else
                            issue(rmm_pkg::CMD_REMOVE, sb.any_held());
                    end
                    issue(rmm_pkg::CMD_QUERY, $urandom);
                end
                default:
                begin
                    repeat (40)
                    begin
                        pick = $urandom_range(0, 19);
                        if (pick < 9)
                            issue(rmm_pkg::CMD_INSERT, any_value());
                        else if (pick < 13 && sb.held_count() > 0)
                            issue(rmm_pkg::CMD_REMOVE, sb.any_held());
                        else if (pick < 15)
                            issue(rmm_pkg::CMD_REMOVE, any_value());
                        else if (pick < 19)
                            issue(rmm_pkg::CMD_QUERY, $urandom);
                        else
                            issue(CMD_NOP, $urandom);
                    end
                end
            endcase
            phase_no++;
        end
        cmd_valid <= 1'b0;

        guard = 0;
        while (sb.pending_count() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.pending_count()));

        $display("covered %0d command words: %0d medians, %0d empty queries,",
                 sb.words_noted, sb.medians_ok, sb.empty_queries);
        $display("%0d dropped inserts, %0d missed removes, store peaked at %0d of %0d",
                 sb.dropped_inserts, sb.missed_removes, sb.peak_count, STORE_DEPTH);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", sb.pending_count());
        $display("FAILURE");
        $finish;
    end

endmodule
